// ===== src/ptc_pkg.sv =====
// Shared types and constants for the polyline tangent colour unit.
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int NORM_BITS = 30;
  localparam int SUM_W     = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = NORM_BITS + 2;
  localparam int COLOUR_W  = 8;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_ROOT,
    U_DIV,
    U_DONE
  } ptc_unit_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD_START,
    ST_FWD_WAIT,
    ST_SUM_START,
    ST_SUM_WAIT,
    ST_EMIT1,
    ST_EMIT2,
    ST_FINISH
  } ptc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } ptc_unit_stat_t;

endpackage

// ===== src/ptc_if.sv =====
// Input and output channel interfaces of the polyline tangent colour unit.
`timescale 1ns / 1ps
interface ptc_in_if #(
  parameter int COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          is_break;
  logic                          curve_end;

  modport source (output valid, pos_x, pos_y, pos_z, is_break, curve_end, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, is_break, curve_end, output ready);
endinterface

interface ptc_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       was_break;
  logic       last_of_curve;

  modport source (output valid, red, green, blue, was_break, last_of_curve, input ready);
  modport sink   (input valid, red, green, blue, was_break, last_of_curve, output ready);
endinterface

// ===== src/polyline_tangent_color_unit.sv =====
// Top level: vertex hold, tangent sequencing and colour output register.
// When a forward difference is needed, the vertex takes two unit-vector passes (forward
// direction, then the sum with the backward direction), each a start, normalise, square,
// root, divide and done phase, before its first word; otherwise no pass is made.
// Input ready is low from acceptance until the vertex retires, output stalls included.
// Reset: asynchronous, clears the hold, the backward direction, out valid.
`timescale 1ns / 1ps
module polyline_tangent_color_unit #(
  parameter int COORD_WIDTH    = 24,
  parameter int UNIT_FRAC_BITS = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptc_in_if.sink    in_i,
  ptc_out_if.source out_o
);
  import ptc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int UW = UNIT_FRAC_BITS + 2;
  localparam int SW = UW + 1;
  localparam int VW = (DW > SW) ? DW : SW;

  ptc_state_e state_q, state_d;

  logic signed [COORD_WIDTH-1:0] held_q [3];
  logic signed [COORD_WIDTH-1:0] held_d [3];
  logic signed [COORD_WIDTH-1:0] inp_q [3];
  logic signed [COORD_WIDTH-1:0] inp_d [3];
  logic signed [UW-1:0] back_q [3];
  logic signed [UW-1:0] back_d [3];
  logic signed [UW-1:0] nb_q [3];
  logic signed [UW-1:0] nb_d [3];
  logic signed [UW-1:0] tan_q [3];
  logic signed [UW-1:0] tan_d [3];
  logic held_present_q, held_present_d;
  logic held_break_q, held_break_d;
  logic back_valid_q, back_valid_d;
  logic nb_valid_q, nb_valid_d;
  logic in_brk_q, in_brk_d;
  logic in_end_q, in_end_d;

  logic                out_valid_q, out_valid_d;
  logic [COLOUR_W-1:0] col_q [3];
  logic [COLOUR_W-1:0] col_d [3];
  logic                out_brk_q, out_brk_d;
  logic                out_last_q, out_last_d;

  logic signed [DW-1:0] diff [3];
  logic signed [VW-1:0] vec [3];
  logic signed [UW-1:0] unit_v [3];
  logic [UW-1:0]        mag_t [3];
  logic [UW+7:0]        scaled [3];
  logic [COLOUR_W-1:0]  colour [3];
  logic                 unit_start;
  logic                 out_free;
  logic                 accept;
  ptc_unit_stat_t       unit_stat;

  ptc_unitize #(
    .VEC_W (VW),
    .FRAC  (UNIT_FRAC_BITS)
  ) u_unitize (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .vec_i   (vec),
    .unit_o  (unit_v),
    .stat_o  (unit_stat)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign unit_start = (state_q == ST_FWD_START) || (state_q == ST_SUM_START);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DW'(inp_q[i]) - DW'(held_q[i]);
      if (state_q == ST_SUM_START) begin
        vec[i] = VW'(nb_q[i]) + (back_valid_q ? VW'(back_q[i]) : VW'(0));
      end else begin
        vec[i] = VW'(diff[i]);
      end
      // floor(255 * |t|) as (|t| << 8) - |t|, then drop the fraction
      mag_t[i]  = tan_q[i][UW-1] ? (~tan_q[i] + 1'b1) : tan_q[i];
      scaled[i] = {mag_t[i], 8'b0} - (UW+8)'(mag_t[i]);
      colour[i] = scaled[i][UNIT_FRAC_BITS +: COLOUR_W];
    end
  end

  always_comb begin
    state_d        = state_q;
    held_d         = held_q;
    inp_d          = inp_q;
    back_d         = back_q;
    nb_d           = nb_q;
    tan_d          = tan_q;
    held_present_d = held_present_q;
    held_break_d   = held_break_q;
    back_valid_d   = back_valid_q;
    nb_valid_d     = nb_valid_q;
    in_brk_d       = in_brk_q;
    in_end_d       = in_end_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    col_d          = col_q;
    out_brk_d      = out_brk_q;
    out_last_d     = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          inp_d[0]   = in_i.pos_x;
          inp_d[1]   = in_i.pos_y;
          inp_d[2]   = in_i.pos_z;
          in_brk_d   = in_i.is_break;
          in_end_d   = in_i.curve_end;
          nb_valid_d = 1'b0;
          for (int i = 0; i < 3; i++) nb_d[i] = '0;
          if (held_present_q) begin
            if (!in_i.is_break && !held_break_q) begin
              state_d = ST_FWD_START;
            end else begin
              for (int i = 0; i < 3; i++) tan_d[i] = back_valid_q ? back_q[i] : '0;
              state_d = ST_EMIT1;
            end
          end else if (in_i.curve_end) begin
            for (int i = 0; i < 3; i++) tan_d[i] = '0;
            state_d = ST_EMIT2;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FWD_START: state_d = ST_FWD_WAIT;
      ST_FWD_WAIT: begin
        if (unit_stat.done) begin
          nb_d       = unit_v;
          nb_valid_d = 1'b1;
          state_d    = ST_SUM_START;
        end
      end
      ST_SUM_START: state_d = ST_SUM_WAIT;
      ST_SUM_WAIT: begin
        if (unit_stat.done) begin
          tan_d   = unit_v;
          state_d = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          for (int i = 0; i < 3; i++) col_d[i] = held_break_q ? '0 : colour[i];
          out_brk_d  = held_break_q;
          out_last_d = 1'b0;
          if (in_end_q) begin
            for (int i = 0; i < 3; i++) tan_d[i] = nb_valid_q ? nb_q[i] : '0;
            state_d = ST_EMIT2;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          for (int i = 0; i < 3; i++) col_d[i] = in_brk_q ? '0 : colour[i];
          out_brk_d  = in_brk_q;
          out_last_d = 1'b1;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // drop the hold at curve end, otherwise advance it to the new vertex
        if (in_end_q) begin
          held_present_d = 1'b0;
          held_break_d   = 1'b0;
          back_valid_d   = 1'b0;
        end else begin
          held_d         = inp_q;
          held_present_d = 1'b1;
          held_break_d   = in_brk_q;
          back_d         = nb_q;
          back_valid_d   = nb_valid_q;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      held_present_q <= 1'b0;
      held_break_q   <= 1'b0;
      back_valid_q   <= 1'b0;
      nb_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      held_present_q <= held_present_d;
      held_break_q   <= held_break_d;
      back_valid_q   <= back_valid_d;
      nb_valid_q     <= nb_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q     <= held_d;
    inp_q      <= inp_d;
    back_q     <= back_d;
    nb_q       <= nb_d;
    tan_q      <= tan_d;
    in_brk_q   <= in_brk_d;
    in_end_q   <= in_end_d;
    col_q      <= col_d;
    out_brk_q  <= out_brk_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.red           = col_q[0];
  assign out_o.green         = col_q[1];
  assign out_o.blue          = col_q[2];
  assign out_o.was_break     = out_brk_q;
  assign out_o.last_of_curve = out_last_q;

  a_ready_engine_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !unit_stat.busy)
    else $error("input ready while the unit-vector engine is busy");

  a_break_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.was_break |->
      out_o.red == 8'd0 && out_o.green == 8'd0 && out_o.blue == 8'd0)
    else $error("terminal vertex word carries a non-zero colour");

  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_stat.done |-> state_q == ST_FWD_WAIT || state_q == ST_SUM_WAIT)
    else $error("unit-vector engine finished outside a wait state");

endmodule

// ===== src/ptc_unitize.sv =====
// Iterative unit-vector engine: normalising shift, squares, square root, divisions.
`timescale 1ns / 1ps
module ptc_unitize #(
  parameter int VEC_W = 26,
  parameter int FRAC  = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [VEC_W-1:0]  vec_i [3],
  output logic signed [FRAC+1:0]   unit_o [3],
  output ptc_pkg::ptc_unit_stat_t  stat_o
);
  import ptc_pkg::*;

  localparam int XW   = ((VEC_W > NORM_BITS) ? VEC_W : NORM_BITS) + 1;
  localparam int STPW = $clog2(FRAC + 1);

  ptc_unit_state_e state_q, state_d;

  logic [XW-1:0]         mag_q [3];
  logic [XW-1:0]         mag_d [3];
  logic                  neg_q [3];
  logic                  neg_d [3];
  logic [2*NORM_BITS-1:0] prod_q, prod_d;
  logic [SUM_W-1:0]      acc_q, acc_d;
  logic [SUM_W-1:0]      root_q, root_d;
  logic [SUM_W-1:0]      bit_q, bit_d;
  logic [ROOT_W-1:0]     rem_q, rem_d;
  logic [FRAC:0]         quot_q, quot_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [STPW-1:0]       step_q, step_d;
  logic signed [FRAC+1:0] comp_q [3];
  logic signed [FRAC+1:0] comp_d [3];

  logic [VEC_W-1:0]      abs_v [3];
  logic [XW-1:0]         orv;
  logic [NORM_BITS-1:0]  sel_mag;
  logic                  sel_neg;
  logic [SUM_W-1:0]      trial;
  logic [ROOT_W:0]       div_t;
  logic [ROOT_W:0]       div_n;
  logic                  qb;
  logic [FRAC:0]         qfin;
  logic [FRAC+1:0]       qext;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vec_i[i][VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    orv = mag_q[0] | mag_q[1] | mag_q[2];
    case (cnt_q)
      2'd0:    begin sel_mag = mag_q[0][NORM_BITS-1:0]; sel_neg = neg_q[0]; end
      2'd1:    begin sel_mag = mag_q[1][NORM_BITS-1:0]; sel_neg = neg_q[1]; end
      2'd2:    begin sel_mag = mag_q[2][NORM_BITS-1:0]; sel_neg = neg_q[2]; end
      default: begin sel_mag = '0; sel_neg = 1'b0; end
    endcase
    trial = root_q + bit_q;
    div_n = {1'b0, root_q[ROOT_W-1:0]};
    div_t = (step_q == '0) ? (ROOT_W+1)'(sel_mag) : {rem_q, 1'b0};
    qb    = (div_t >= div_n);
    qfin  = {quot_q[FRAC-1:0], qb};
    if (qfin > (FRAC+1)'(1) << FRAC) qfin = (FRAC+1)'(1) << FRAC;
    qext  = {1'b0, qfin};
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    root_d  = root_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    comp_d  = comp_q;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_d[i]  = vec_i[i][VEC_W-1];
            mag_d[i]  = XW'(abs_v[i]);
            comp_d[i] = '0;
          end
          state_d = U_NORM;
        end
      end
      U_NORM: begin
        // shift all magnitudes together until the largest is exactly NORM_BITS long
        if (orv == '0) begin
          state_d = U_DONE;
        end else if ((orv >> NORM_BITS) != '0) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (!orv[NORM_BITS-1]) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          prod_d  = '0;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = U_SQ;
        end
      end
      U_SQ: begin
        prod_d = (cnt_q != 2'd3) ? sel_mag * sel_mag : '0;
        acc_d  = acc_q + SUM_W'(prod_q);
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          root_d  = '0;
          bit_d   = SUM_W'(1) << (SUM_W - 2);
          state_d = U_ROOT;
        end
      end
      U_ROOT: begin
        if (acc_q >= trial) begin
          acc_d  = acc_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          cnt_d   = '0;
          step_d  = '0;
          quot_d  = '0;
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        rem_d  = qb ? ROOT_W'(div_t - div_n) : div_t[ROOT_W-1:0];
        quot_d = qfin;
        step_d = step_q + 1'b1;
        if (step_q == STPW'(FRAC)) begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_q == 2'(i)) comp_d[i] = $signed(sel_neg ? (~qext + 1'b1) : qext);
          end
          step_d = '0;
          quot_d = '0;
          cnt_d  = cnt_q + 2'd1;
          if (cnt_q == 2'd2) state_d = U_DONE;
        end
      end
      U_DONE: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
    step_q <= step_d;
    comp_q <= comp_d;
  end

  assign unit_o      = comp_q;
  assign stat_o.busy = (state_q != U_IDLE);
  assign stat_o.done = (state_q == U_DONE);

endmodule
